// File: src/gasp_pkg.sv
// Shared types, constants and helpers for the glyph atlas shelf packer.
package gasp_pkg;

	localparam int NUM_CODES_DEF = 4096;
	localparam int CODE_W        = 12;
	localparam int GLYPH_W       = 8;
	localparam int BEAR_W        = 10;
	localparam int COORD_W       = 13;
	localparam int FONT_W        = 8;
	localparam int IDX_EXT_W     = 17;
	localparam int CFG_IDX_W     = 1;

	localparam logic [COORD_W-1:0] COORD_MAX   = 13'd8191;
	localparam logic [FONT_W-1:0]  FONT_RESET  = 8'd16;
	localparam logic [COORD_W-1:0] ATLAS_RESET = 13'd512;

	localparam logic [CFG_IDX_W-1:0] REG_FONT_SIZE   = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_ATLAS_WIDTH = 1'b1;

	typedef struct packed {
		logic [BEAR_W-1:0]  glyph_top;
		logic [BEAR_W-1:0]  glyph_left;
		logic [GLYPH_W-1:0] glyph_rows;
		logic [GLYPH_W-1:0] glyph_width;
		logic [CODE_W-1:0]  char_code;
	} req_t;

	typedef struct packed {
		logic [BEAR_W-1:0]  bearing_y;
		logic [BEAR_W-1:0]  bearing_x;
		logic [COORD_W-1:0] rect_y1;
		logic [COORD_W-1:0] rect_x1;
		logic [COORD_W-1:0] rect_y0;
		logic [COORD_W-1:0] rect_x0;
	} entry_t;

	localparam int REQ_W   = $bits(req_t);
	localparam int ENTRY_W = $bits(entry_t);

	typedef struct packed {
		logic [FONT_W-1:0]  font_size;
		logic [COORD_W-1:0] atlas_width;
	} cfg_t;

	function automatic logic [COORD_W-1:0] sat_add(input logic [COORD_W-1:0] a,
			input logic [GLYPH_W:0] b);
		logic [COORD_W:0] s;
		s = {1'b0, a} + {{(COORD_W-GLYPH_W){1'b0}}, b};
		return s[COORD_W] ? COORD_MAX : s[COORD_W-1:0];
	endfunction

	function automatic logic [GLYPH_W-1:0] max8(input logic [GLYPH_W-1:0] a,
			input logic [GLYPH_W-1:0] b);
		return (a > b) ? a : b;
	endfunction

endpackage

// File: src/gasp_ram.sv
// Generic single-write, single-read RAM with registered read data.
module gasp_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

// File: src/gasp_shelf.sv
// Shelf cursor state and placement of one glyph on a table miss.
module gasp_shelf import gasp_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   commit,
	input  req_t   req,
	input  cfg_t   cfg,
	output entry_t placed
);

	logic [COORD_W-1:0] cursor_x_q, cursor_y_q;
	logic [GLYPH_W-1:0] widest_q, tallest_q;

	logic [GLYPH_W-1:0] span_w, span_h, half;
	logic               wrap, blank;
	logic [COORD_W-1:0] cx, cy, next_x;

	always_comb begin
		span_w = max8(widest_q, cfg.font_size);
		span_h = max8(tallest_q, cfg.font_size);
		wrap   = ({1'b0, cursor_x_q} + {{(COORD_W-GLYPH_W+1){1'b0}}, span_w})
			> {1'b0, cfg.atlas_width};
		cx     = wrap ? '0 : cursor_x_q;
		cy     = wrap ? sat_add(cursor_y_q, {1'b0, span_h}) : cursor_y_q;
		blank  = (req.glyph_width == '0) || (req.glyph_rows == '0);
		half   = cfg.font_size >> 1;

		placed.rect_x0 = cx;
		placed.rect_y0 = cy;
		if (blank) begin
			placed.rect_x1   = sat_add(cx, {1'b0, half});
			placed.rect_y1   = (cfg.font_size == '0) ? cy
				: sat_add(cy, {1'b0, cfg.font_size - 8'd1});
			placed.bearing_x = '0;
			placed.bearing_y = {{(BEAR_W-FONT_W){1'b0}}, cfg.font_size} - 10'd1;
			next_x           = sat_add(cx, {1'b0, half});
		end else begin
			placed.rect_x1   = sat_add(cx, {1'b0, req.glyph_width});
			placed.rect_y1   = sat_add(cy, {1'b0, req.glyph_rows});
			placed.bearing_x = req.glyph_left;
			placed.bearing_y = req.glyph_top;
			next_x           = sat_add(cx, {1'b0, req.glyph_width} + 9'd1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cursor_x_q <= '0;
			cursor_y_q <= '0;
			widest_q   <= '0;
			tallest_q  <= '0;
		end else if (commit) begin
			cursor_x_q <= next_x;
			cursor_y_q <= cy;
			if (!blank) begin
				widest_q  <= max8(widest_q, req.glyph_width);
				tallest_q <= max8(tallest_q, req.glyph_rows);
			end
		end
	end

endmodule

// File: src/glyph_atlas_shelf_packer.sv
// Top level of the glyph atlas shelf packer.
// Each input is registered in s1, then in s2. Throughput: one item per cycle
// unless the output stalls; table write-back is forwarded to a following read.
// Reset: cursors and registers clear at once, then a clearing pass writes all
// NUM_CODES table entries, one per cycle, with s_axis_tready held low for that time.
// Configuration writes are taken in every cycle.
module glyph_atlas_shelf_packer import gasp_pkg::*; #(
	parameter int NUM_CODES = NUM_CODES_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_axis_tvalid,
	output logic                 s_axis_tready,
	// char_code, glyph_width, glyph_rows, glyph_left, glyph_top
	input  logic [REQ_W-1:0]     s_axis_tdata,
	output logic                 m_axis_tvalid,
	input  logic                 m_axis_tready,
	// rect_x0, rect_y0, rect_x1, rect_y1, bearing_x, bearing_y
	output logic [ENTRY_W-1:0]   m_axis_tdata,
	// newly_placed
	output logic                 m_axis_tuser,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [COORD_W-1:0]   cfg_data
);

	localparam int AW = $clog2(NUM_CODES);

	cfg_t            cfg_q;
	logic            clr_q;
	logic [AW-1:0]   clr_addr_q;

	logic            v1_s1, fwd_s1;
	req_t            req_s1;
	entry_t          fwd_data_s1;
	entry_t          out_s2;
	logic            placed_s2, v2_s2;

	logic            in_acc, adv1, inrange1, miss, go;
	logic [IDX_EXT_W-1:0] code_ext1;
	logic [AW-1:0]   rd_addr, wr_addr;
	logic            wr_en;
	entry_t          wr_data, rd_data, entry_rd, shelf_entry, result;
	logic [ENTRY_W-1:0] ram_rd;
	req_t            req_in;

	assign cfg_ready     = 1'b1;
	assign req_in        = req_t'(s_axis_tdata);
	assign adv1          = v1_s1 && (!v2_s2 || m_axis_tready);
	assign s_axis_tready = !clr_q && (!v1_s1 || adv1);
	assign in_acc        = s_axis_tvalid && s_axis_tready;
	assign rd_addr       = AW'({{(IDX_EXT_W-CODE_W){1'b0}}, req_in.char_code});

	assign code_ext1 = {{(IDX_EXT_W-CODE_W){1'b0}}, req_s1.char_code};
	assign inrange1  = code_ext1 < IDX_EXT_W'(NUM_CODES);
	assign rd_data   = entry_t'(ram_rd);
	assign entry_rd  = fwd_s1 ? fwd_data_s1 : rd_data;
	assign miss      = (entry_rd.rect_x0 == '0) && (entry_rd.rect_y0 == '0)
		&& (entry_rd.rect_x1 == '0) && (entry_rd.rect_y1 == '0);
	assign go        = adv1 && inrange1 && miss;
	assign result    = !inrange1 ? '0 : (miss ? shelf_entry : entry_rd);

	assign wr_en   = clr_q || go;
	assign wr_addr = clr_q ? clr_addr_q : code_ext1[AW-1:0];
	assign wr_data = clr_q ? '0 : shelf_entry;

	gasp_ram #(
		.WIDTH(ENTRY_W),
		.DEPTH(NUM_CODES)
	) u_table (
		.clk    (clk),
		.wr_en  (wr_en),
		.wr_addr(wr_addr),
		.wr_data(wr_data),
		.rd_en  (in_acc),
		.rd_addr(rd_addr),
		.rd_data(ram_rd)
	);

	gasp_shelf u_shelf (
		.clk   (clk),
		.arst_n(arst_n),
		.commit(go),
		.req   (req_s1),
		.cfg   (cfg_q),
		.placed(shelf_entry)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.font_size   <= FONT_RESET;
			cfg_q.atlas_width <= ATLAS_RESET;
			clr_q             <= 1'b1;
			clr_addr_q        <= '0;
			v1_s1             <= 1'b0;
			fwd_s1            <= 1'b0;
			v2_s2             <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				unique case (cfg_index)
					REG_FONT_SIZE:   cfg_q.font_size   <= cfg_data[FONT_W-1:0];
					REG_ATLAS_WIDTH: cfg_q.atlas_width <= cfg_data;
					default: ;
				endcase
			end
			if (clr_q) begin
				clr_addr_q <= clr_addr_q + AW'(1);
				if (clr_addr_q == AW'(NUM_CODES - 1)) begin
					clr_q <= 1'b0;
				end
			end
			if (in_acc) begin
				v1_s1  <= 1'b1;
				fwd_s1 <= go && (wr_addr == rd_addr);
			end else if (adv1) begin
				v1_s1 <= 1'b0;
			end
			if (adv1) begin
				v2_s2 <= 1'b1;
			end else if (m_axis_tready) begin
				v2_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			req_s1      <= req_in;
			fwd_data_s1 <= shelf_entry;
		end
		if (adv1) begin
			out_s2    <= result;
			placed_s2 <= inrange1 && miss;
		end
	end

	assign m_axis_tvalid = v2_s2;
	assign m_axis_tdata  = out_s2;
	assign m_axis_tuser  = placed_s2;

endmodule

// File: src/gasp_checker.sv
// Port-level checks for the glyph atlas shelf packer, bound to the top level.
module gasp_checker import gasp_pkg::*; (
	input logic                 clk,
	input logic                 arst_n,
	input logic                 s_axis_tvalid,
	input logic                 s_axis_tready,
	input logic                 m_axis_tvalid,
	input logic                 m_axis_tready,
	input logic [ENTRY_W-1:0]   m_axis_tdata,
	input logic                 m_axis_tuser,
	input logic                 cfg_valid,
	input logic                 cfg_ready
);

	entry_t res;
	assign res = entry_t'(m_axis_tdata);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=>
		m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
		else $error("result changed while stalled");

	a_rect_order: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (res.rect_x1 >= res.rect_x0) && (res.rect_y1 >= res.rect_y0))
		else $error("rectangle corners out of order");

	a_result_cause: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_axis_tvalid) |-> $past(s_axis_tvalid && s_axis_tready, 2))
		else $error("result without matching input transfer");

	a_cfg_ready: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid |-> cfg_ready)
		else $error("configuration write stalled");

endmodule

bind glyph_atlas_shelf_packer gasp_checker u_gasp_checker (.*);
